### rtl/core/semc_pkg.sv
// ----------------------------------------------------------------------------
// semc_pkg
// Shared codes, field widths and the control word for the wait queue cells.
// ----------------------------------------------------------------------------
package semc_pkg;

  localparam int CMD_W = 3;
  localparam int ID_W  = 6;
  localparam int ST_W  = 4;
  localparam int AVAIL_W = 16;
  localparam int WAITERS_W = 5;

  localparam logic [CMD_W-1:0] CMD_ACQUIRE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TRY       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TIMEOUT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SIGNAL    = 3'd4;

  localparam logic [ST_W-1:0] ST_GRANTED  = 4'd0;
  localparam logic [ST_W-1:0] ST_QUEUED   = 4'd1;
  localparam logic [ST_W-1:0] ST_BUSY     = 4'd2;
  localparam logic [ST_W-1:0] ST_RAISED   = 4'd3;
  localparam logic [ST_W-1:0] ST_HANDOFF  = 4'd4;
  localparam logic [ST_W-1:0] ST_TIMEDOUT = 4'd5;
  localparam logic [ST_W-1:0] ST_INTR     = 4'd6;
  localparam logic [ST_W-1:0] ST_NOTWAIT  = 4'd7;
  localparam logic [ST_W-1:0] ST_FULL     = 4'd8;
  localparam logic [ST_W-1:0] ST_SAT      = 4'd9;

  typedef struct packed {
    logic            append;
    logic            pop;
    logic            cancel;
    logic [ID_W-1:0] new_id;
    logic [ID_W-1:0] probe_id;
  } cell_ctl_t;

endpackage

### rtl/core/semc_cell.sv
// ----------------------------------------------------------------------------
// semc_cell
// One slot of the wait queue. Loads a new id at the tail, matches cancel
// probes and shifts the upper neighbor down when it or a slot below it is removed.
// ----------------------------------------------------------------------------
module semc_cell (
  input  logic                        clk,
  input  semc_pkg::cell_ctl_t         ctl,
  input  logic                        occupied,
  input  logic                        at_tail,
  input  logic [semc_pkg::ID_W-1:0]   next_id,
  input  logic                        hit_in,
  output logic [semc_pkg::ID_W-1:0]   id,
  output logic                        hit_out
);
  import semc_pkg::*;

  logic [ID_W-1:0] id_r;
  logic            match;

  assign match   = ctl.cancel && occupied && (id_r == ctl.probe_id);
  assign hit_out = hit_in || match;
  assign id      = id_r;

  always_ff @(posedge clk) begin
    if (hit_out) begin
      id_r <= next_id;
    end else if (ctl.append && at_tail) begin
      id_r <= ctl.new_id;
    end
  end

endmodule

### rtl/core/counting_semaphore_fifo_waiters.sv
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters
// Counting semaphore with a first-in first-out queue of waiting ids.
// ----------------------------------------------------------------------------
// Each input word carries a command in in_tuser and a waiter id in in_tdata.
// Each accepted word yields exactly one result word in the following cycle, with the
// status in out_tuser and the woken id, free count and queue length in
// out_tdata. A word is taken in every cycle while the output register is
// empty or being drained, so the block sustains one word per cycle; the
// limit is the single registered pass through the row of queue cells.
// When the receiver stalls, the result is held and in_tready drops until it
// is taken. The wait queue is a row of cells: a removal ripples a hit flag
// up the row, and the hit cell and every cell above it take their upper neighbor's id.
// Reset sets the free count to 1 and empties the queue. A word on the cfg
// channel sets the free count to the written value and empties the queue;
// the user must write it only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters #(
  parameter int QUEUE_DEPTH = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [5:0] waiter_id
  input  logic [2:0]  in_tuser,   // [2:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [5:0] woken_id, [21:6] available_now, [26:22] waiters_now
  output logic [3:0]  out_tuser,  // [3:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import semc_pkg::*;

  localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] free_r, free_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic                  out_valid_r;
  logic [ST_W-1:0]       st_r, st_nxt;
  logic [ID_W-1:0]       woken_r, woken_nxt;
  logic [COUNT_BITS-1:0] avail_r;
  logic [LEN_W-1:0]      wait_r;

  logic                  in_acc;
  logic [CMD_W-1:0]      cmd;
  logic [ID_W-1:0]       wid;
  cell_ctl_t             ctl;
  logic [ID_W-1:0]       ids [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]  hit;
  logic                  found;
  logic [31:0]           free_ext;
  logic [31:0]           cfg_ext;
  logic [6:0]            len_ext;

  assign cmd       = in_tuser;
  assign wid       = in_tdata[ID_W-1:0];
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_ext   = 32'(cfg_data);

  assign ctl.append   = in_acc && (cmd == CMD_ACQUIRE) && (free_r == '0) &&
                        (len_r != LEN_W'(QUEUE_DEPTH));
  assign ctl.pop      = in_acc && (cmd == CMD_RELEASE) && (len_r != '0);
  assign ctl.cancel   = in_acc && ((cmd == CMD_TIMEOUT) || (cmd == CMD_SIGNAL));
  assign ctl.new_id   = wid;
  assign ctl.probe_id = wid;

  assign hit[0] = ctl.pop;
  assign found  = hit[QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [ID_W-1:0] nid;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nid = ids[i];
    end else begin : g_mid
      assign nid = ids[i+1];
    end
    semc_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occupied (LEN_W'(i) < len_r),
      .at_tail  (LEN_W'(i) == len_r),
      .next_id  (nid),
      .hit_in   (hit[i]),
      .id       (ids[i]),
      .hit_out  (hit[i+1])
    );
  end

  always_comb begin
    free_nxt  = free_r;
    len_nxt   = len_r;
    st_nxt    = ST_NOTWAIT;
    woken_nxt = '0;
    unique case (cmd)
      CMD_ACQUIRE: begin
        if (free_r != '0) begin
          free_nxt = free_r - 1'b1;
          st_nxt   = ST_GRANTED;
        end else if (ctl.append) begin
          len_nxt = len_r + 1'b1;
          st_nxt  = ST_QUEUED;
        end else begin
          st_nxt = ST_FULL;
        end
      end
      CMD_TRY: begin
        if (free_r != '0) begin
          free_nxt = free_r - 1'b1;
          st_nxt   = ST_GRANTED;
        end else begin
          st_nxt = ST_BUSY;
        end
      end
      CMD_RELEASE: begin
        if (len_r != '0) begin
          woken_nxt = ids[0];
          len_nxt   = len_r - 1'b1;
          st_nxt    = ST_HANDOFF;
        end else if (free_r != COUNT_MAX) begin
          free_nxt = free_r + 1'b1;
          st_nxt   = ST_RAISED;
        end else begin
          st_nxt = ST_SAT;
        end
      end
      CMD_TIMEOUT, CMD_SIGNAL: begin
        if (found) begin
          len_nxt = len_r - 1'b1;
          st_nxt  = (cmd == CMD_TIMEOUT) ? ST_TIMEDOUT : ST_INTR;
        end
      end
      default: begin
        st_nxt = ST_NOTWAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r      <= COUNT_BITS'(1);
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        free_r <= cfg_ext[COUNT_BITS-1:0];
        len_r  <= '0;
      end else if (in_acc) begin
        free_r <= free_nxt;
        len_r  <= len_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      st_r    <= st_nxt;
      woken_r <= woken_nxt;
      avail_r <= free_nxt;
      wait_r  <= len_nxt;
    end
  end

  assign free_ext   = 32'(avail_r);
  assign len_ext    = 7'(wait_r);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = st_r;
  assign out_tdata  = {5'b0, len_ext[WAITERS_W-1:0], free_ext[AVAIL_W-1:0], woken_r};

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(QUEUE_DEPTH))
    else $error("wait queue length beyond depth");

  a_handoff_len: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !cfg_valid && cmd == CMD_RELEASE && len_r != '0
    |=> len_r == $past(len_r) - 1'b1 && st_r == ST_HANDOFF)
    else $error("hand-off did not shorten the queue");

  a_grant_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !cfg_valid && (cmd == CMD_ACQUIRE || cmd == CMD_TRY) && free_r != '0
    |=> free_r == $past(free_r) - 1'b1 && len_r == $past(len_r))
    else $error("grant did not take exactly one unit");

endmodule
